// ----- src/csqrt_pkg.sv -----
// package for the complex square root core
// holds the fixed field widths and the transfer payload types; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package csqrt_pkg;
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] real_in;
    logic signed [DATA_WIDTH-1:0] imag_in;
  } csqrt_in_t;

  typedef struct packed {
    logic [DATA_WIDTH-2:0]        root_real;
    logic signed [DATA_WIDTH-1:0] root_imag;
  } csqrt_out_t;
endpackage
`default_nettype wire

// ----- src/csqrt_cell.sv -----
// one cell of the digit-by-digit square root chain: settles one root bit
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none
module csqrt_cell #(
  parameter int RW = 32,
  parameter int SW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            valid_i,
  input  wire logic [2*RW-1:0] rad_i,
  input  wire logic [RW+1:0]   rem_i,
  input  wire logic [RW-1:0]   root_i,
  input  wire logic [SW-1:0]   side_i,
  output logic                 valid_o,
  output logic [2*RW-1:0]      rad_o,
  output logic [RW+1:0]        rem_o,
  output logic [RW-1:0]        root_o,
  output logic [SW-1:0]        side_o
);
  logic [RW+3:0] t;
  logic [RW+3:0] trial;
  logic          ge;
  logic          valid_r;
  logic [2*RW-1:0] rad_r;
  logic [RW+1:0] rem_r;
  logic [RW-1:0] root_r;
  logic [SW-1:0] side_r;

  always_comb begin
    t     = {rem_i, rad_i[2*RW-1 -: 2]};
    trial = (RW+4)'({root_i, 2'b01});
    ge    = (t >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_i << 2;
      rem_r  <= ge ? (RW+2)'(t - trial) : (RW+2)'(t);
      root_r <= {root_i[RW-2:0], ge};
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign rad_o   = rad_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign side_o  = side_r;
endmodule
`default_nettype wire

// ----- src/csqrt_isqrt.sv -----
// integer floor square root as a row of csqrt_cell stages, one root bit each
// depends on csqrt_cell
`timescale 1ns / 1ps
`default_nettype none
module csqrt_isqrt #(
  parameter int RW = 32,
  parameter int SW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            valid_i,
  input  wire logic [2*RW-1:0] rad_i,
  input  wire logic [SW-1:0]   side_i,
  output logic                 valid_o,
  output logic [RW-1:0]        root_o,
  output logic [SW-1:0]        side_o
);
  logic            v    [RW+1];
  logic [2*RW-1:0] rad  [RW+1];
  logic [RW+1:0]   rem  [RW+1];
  logic [RW-1:0]   root [RW+1];
  logic [SW-1:0]   side [RW+1];

  assign v[0]    = valid_i;
  assign rad[0]  = rad_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = side_i;

  for (genvar i = 0; i < RW; i++) begin : g_cell
    csqrt_cell #(.RW(RW), .SW(SW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_i(v[i]), .rad_i(rad[i]), .rem_i(rem[i]), .root_i(root[i]), .side_i(side[i]),
      .valid_o(v[i+1]), .rad_o(rad[i+1]), .rem_o(rem[i+1]), .root_o(root[i+1]),
      .side_o(side[i+1])
    );
  end

  assign valid_o = v[RW];
  assign root_o  = root[RW];
  assign side_o  = side[RW];
endmodule
`default_nettype wire

// ----- src/complex_square_root_core.sv -----
// top level of the complex principal square root core
// depends on csqrt_pkg and csqrt_isqrt
//
// usage: one complex operand per in_ transfer (in_data.real_in, in_data.imag_in,
// signed Q16.16), one result per out_ transfer (out_data.root_real unsigned
// Q15.16, out_data.root_imag signed Q16.16, both truncated).
// the modulus floor root takes one cell per root bit (DATA_WIDTH cells), then
// the two half-sum roots run side by side in (DATA_WIDTH+FRAC_BITS+1)/2 cells.
// the stages in order are input register, squares, sum, modulus cells,
// half-sum register, root cells and output register.
// throughput is one transfer per cycle while the pipeline is not held; the cell
// rows carry a new item every cycle while earlier items are still in flight.
// the whole pipeline advances as one: when out_stall holds a waiting result,
// every stage holds and in_stall is raised until the result is taken.
// reset clears all valid flags; nothing else needs clearing and no sweep runs.
`timescale 1ns / 1ps
`default_nettype none
module complex_square_root_core
  import csqrt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire csqrt_in_t  in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output csqrt_out_t      out_data
);
  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int RW2 = (W + F + 1) / 2;

  logic en;
  logic out_valid_r;
  csqrt_out_t out_data_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // stage 0: magnitudes and signs
  logic         v0_r;
  logic [W-1:0] re_mag_r, im_mag_r;
  logic         re_neg0_r, im_neg0_r;
  // stage 1: squares
  logic           v1_r;
  logic [2*W-1:0] re_sq_r, im_sq_r;
  logic [W-1:0]   re_mag1_r;
  logic           re_neg1_r, im_neg1_r;
  // stage 2: sum of squares
  logic           v2_r;
  logic [2*W-1:0] sum_sq_r;
  logic [W-1:0]   re_mag2_r;
  logic           re_neg2_r, im_neg2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_neg0_r <= in_data.real_in[W-1];
      im_neg0_r <= in_data.imag_in[W-1];
      re_mag_r  <= in_data.real_in[W-1] ? W'(-in_data.real_in) : W'(in_data.real_in);
      im_mag_r  <= in_data.imag_in[W-1] ? W'(-in_data.imag_in) : W'(in_data.imag_in);
      re_sq_r   <= re_mag_r * re_mag_r;
      im_sq_r   <= im_mag_r * im_mag_r;
      re_mag1_r <= re_mag_r;
      re_neg1_r <= re_neg0_r;
      im_neg1_r <= im_neg0_r;
      sum_sq_r  <= re_sq_r + im_sq_r;
      re_mag2_r <= re_mag1_r;
      re_neg2_r <= re_neg1_r;
      im_neg2_r <= im_neg1_r;
    end
  end

  // modulus root, carrying re magnitude and both signs alongside
  logic           va;
  logic [W-1:0]   modulus;
  logic [W+1:0]   side_a;

  csqrt_isqrt #(.RW(W), .SW(W+2)) u_mod (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(v2_r), .rad_i(sum_sq_r), .side_i({re_neg2_r, im_neg2_r, re_mag2_r}),
    .valid_o(va), .root_o(modulus), .side_o(side_a)
  );

  // half sums: (m +/- re) shifted up by FRAC_BITS-1
  logic         v3_r;
  logic [W:0]   sum_p_r, sum_m_r;
  logic         im_neg3_r;
  logic [W:0]   mod_ext, re_ext;

  assign mod_ext = (W+1)'(modulus);
  assign re_ext  = (W+1)'(side_a[W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_p_r   <= side_a[W+1] ? mod_ext - re_ext : mod_ext + re_ext;
      sum_m_r   <= side_a[W+1] ? mod_ext + re_ext : mod_ext - re_ext;
      im_neg3_r <= side_a[W];
    end
  end

  logic [2*RW2-1:0] rad_p, rad_m;
  assign rad_p = (2*RW2)'({sum_p_r, {(F-1){1'b0}}});
  assign rad_m = (2*RW2)'({sum_m_r, {(F-1){1'b0}}});

  logic           vp, vm;
  logic [RW2-1:0] rr, ri;
  logic           neg_p, neg_m;

  csqrt_isqrt #(.RW(RW2), .SW(1)) u_re (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(v3_r), .rad_i(rad_p), .side_i(im_neg3_r),
    .valid_o(vp), .root_o(rr), .side_o(neg_p)
  );

  csqrt_isqrt #(.RW(RW2), .SW(1)) u_im (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(v3_r), .rad_i(rad_m), .side_i(im_neg3_r),
    .valid_o(vm), .root_o(ri), .side_o(neg_m)
  );

  logic [W-1:0] ri_ext;
  assign ri_ext = W'(ri);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vp && vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.root_real <= (W-1)'(rr);
      // both lanes carry the same sign bit
      out_data_r.root_imag <= (neg_p && neg_m) ? -ri_ext : ri_ext;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule
`default_nettype wire

// ----- src/csqrt_checker.sv -----
// port-level checks for complex_square_root_core, bound to the top level
// depends on csqrt_pkg
`timescale 1ns / 1ps
`default_nettype none
module csqrt_checker
  import csqrt_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire csqrt_in_t  in_data,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire csqrt_out_t out_data
);
  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a stalled operand stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled operand changed");

  // a blocked result freezes the pipeline, so input must stall
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

  // with no result waiting the input side is open
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind complex_square_root_core csqrt_checker u_csqrt_checker (.*);
`default_nettype wire
